### rtl/frs_pkg.sv
`timescale 1ns / 1ps

package frs_pkg;

  localparam int POP_SIZE_DEF     = 64;
  localparam int FITNESS_BITS_DEF = 16;
  localparam int RAND_BITS_DEF    = 16;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_LOAD   = 2'd1;
  localparam logic [1:0] FUNC_SELECT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic hit;
    logic miss;
  } cell_flags_t;

endpackage

### rtl/fitness_roulette_selector_core.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// input    | in_valid, in_ready   | func, fitness_value, random_fraction
// output   | out_valid, out_ready | status, chosen_index, member_count, total_fitness,
//          |                      | best_fitness, best_index, worst_fitness
//
// Clear, load and unused codes answer in the cycle after the request is taken.
// After S_MUL forms the target, a select passes a running sum down the row of cells,
// one cell per cycle; S_SCAN awaits a hit or miss and S_HOLD answers when output is free.
// Reset clears the statistics; the stored fitness values are not cleared.
// A waiting result holds the output; the next request is taken only when it can land.

module fitness_roulette_selector_core
  import frs_pkg::*;
#(
  parameter int POP_SIZE     = POP_SIZE_DEF,
  parameter int FITNESS_BITS = FITNESS_BITS_DEF,
  parameter int RAND_BITS    = RAND_BITS_DEF,
  localparam int IDX_W  = $clog2(POP_SIZE),
  localparam int CNT_W  = $clog2(POP_SIZE + 1),
  localparam int TOT_W  = FITNESS_BITS + IDX_W,
  localparam int PROD_W = TOT_W + RAND_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              func,
  input  logic [FITNESS_BITS-1:0] fitness_value,
  input  logic [RAND_BITS-1:0]    random_fraction,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [IDX_W-1:0]        chosen_index,
  output logic [CNT_W-1:0]        member_count,
  output logic [TOT_W-1:0]        total_fitness,
  output logic [FITNESS_BITS-1:0] best_fitness,
  output logic [IDX_W-1:0]        best_index,
  output logic [FITNESS_BITS-1:0] worst_fitness
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [TOT_W-1:0]        total;
  logic [FITNESS_BITS-1:0] best_val;
  logic [IDX_W-1:0]        best_pos;
  logic [FITNESS_BITS-1:0] worst_val;
  logic [RAND_BITS-1:0]    frac_q;
  logic [PROD_W-1:0]       target;
  logic                    start;
  logic [1:0]              pend_status;
  logic [IDX_W-1:0]        pend_idx;

  logic                    accept;
  logic                    out_free;
  logic                    result_go;
  logic                    full;
  logic                    load_go;
  logic [POP_SIZE-1:0]     wr_en;
  logic [POP_SIZE-1:0]     live;
  logic [POP_SIZE:0]       tok_act;
  logic [TOT_W-1:0]        tok_sum [POP_SIZE+1];
  cell_flags_t             flags [POP_SIZE];
  logic                    any_hit;
  logic                    any_miss;
  logic [IDX_W-1:0]        hit_idx;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign result_go = (accept && (func != FUNC_SELECT)) || ((state == S_HOLD) && out_free);
  assign full      = count >= CNT_W'(POP_SIZE);
  assign load_go   = accept && (func == FUNC_LOAD) && !full;

  assign tok_act[0] = start;
  assign tok_sum[0] = '0;

  for (genvar i = 0; i < POP_SIZE; i++) begin : g_cell
    assign wr_en[i] = load_go && (count == CNT_W'(i));
    assign live[i]  = count > CNT_W'(i);

    frs_cell #(
      .FITNESS_BITS(FITNESS_BITS),
      .RAND_BITS   (RAND_BITS),
      .TOT_W       (TOT_W),
      .PROD_W      (PROD_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (wr_en[i]),
      .wr_data    (fitness_value),
      .live       (live[i]),
      .target     (target),
      .tok_in_act (tok_act[i]),
      .tok_in_sum (tok_sum[i]),
      .tok_out_act(tok_act[i+1]),
      .tok_out_sum(tok_sum[i+1]),
      .flags      (flags[i])
    );
  end

  always_comb begin
    any_hit  = 1'b0;
    any_miss = tok_act[POP_SIZE];
    hit_idx  = '0;
    for (int i = 0; i < POP_SIZE; i++) begin
      any_hit  = any_hit | flags[i].hit;
      any_miss = any_miss | flags[i].miss;
      if (flags[i].hit) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      start     <= 1'b0;
      count     <= '0;
      total     <= '0;
      best_val  <= '0;
      best_pos  <= '0;
      worst_val <= '1;
    end else begin
      start <= (state == S_MUL);
      if (result_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_CLEAR: begin
                status        <= ST_OK;
                chosen_index  <= '0;
                count         <= '0;
                total         <= '0;
                best_val      <= '0;
                best_pos      <= '0;
                worst_val     <= '1;
                member_count  <= '0;
                total_fitness <= '0;
                best_fitness  <= '0;
                best_index    <= '0;
                worst_fitness <= '1;
              end
              FUNC_LOAD: begin
                chosen_index <= '0;
                if (full) begin
                  status        <= ST_FULL;
                  member_count  <= count;
                  total_fitness <= total;
                  best_fitness  <= best_val;
                  best_index    <= best_pos;
                  worst_fitness <= worst_val;
                end else begin
                  status        <= ST_OK;
                  count         <= count + 1'b1;
                  total         <= total + TOT_W'(fitness_value);
                  member_count  <= count + 1'b1;
                  total_fitness <= total + TOT_W'(fitness_value);
                  if (fitness_value > best_val) begin
                    best_val     <= fitness_value;
                    best_pos     <= count[IDX_W-1:0];
                    best_fitness <= fitness_value;
                    best_index   <= count[IDX_W-1:0];
                  end else begin
                    best_fitness <= best_val;
                    best_index   <= best_pos;
                  end
                  if (fitness_value < worst_val) begin
                    worst_val     <= fitness_value;
                    worst_fitness <= fitness_value;
                  end else begin
                    worst_fitness <= worst_val;
                  end
                end
              end
              FUNC_SELECT: begin
                frac_q <= random_fraction;
                state  <= S_MUL;
              end
              default: begin
                status        <= ST_OK;
                chosen_index  <= '0;
                member_count  <= count;
                total_fitness <= total;
                best_fitness  <= best_val;
                best_index    <= best_pos;
                worst_fitness <= worst_val;
              end
            endcase
          end
        end
        S_MUL: begin
          target <= frac_q * total;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (any_hit) begin
            pend_status <= ST_OK;
            pend_idx    <= hit_idx;
            state       <= S_HOLD;
          end else if (any_miss) begin
            pend_status <= ST_NONE;
            pend_idx    <= '0;
            state       <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            status        <= pend_status;
            chosen_index  <= pend_idx;
            member_count  <= count;
            total_fitness <= total;
            best_fitness  <= best_val;
            best_index    <= best_pos;
            worst_fitness <= worst_val;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/frs_cell.sv
`timescale 1ns / 1ps

module frs_cell
  import frs_pkg::*;
#(
  parameter int FITNESS_BITS = FITNESS_BITS_DEF,
  parameter int RAND_BITS    = RAND_BITS_DEF,
  parameter int TOT_W        = FITNESS_BITS_DEF + 6,
  parameter int PROD_W       = TOT_W + RAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [FITNESS_BITS-1:0] wr_data,
  input  logic                    live,
  input  logic [PROD_W-1:0]       target,
  input  logic                    tok_in_act,
  input  logic [TOT_W-1:0]        tok_in_sum,
  output logic                    tok_out_act,
  output logic [TOT_W-1:0]        tok_out_sum,
  output cell_flags_t             flags
);

  logic [FITNESS_BITS-1:0] value;
  logic                    tok_act;
  logic [TOT_W-1:0]        tok_sum;
  logic [TOT_W-1:0]        sum_new;
  logic                    reached;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_act <= 1'b0;
    end else begin
      tok_act <= tok_in_act;
    end
    tok_sum <= tok_in_sum;
    if (wr_en) begin
      value <= wr_data;
    end
  end

  assign sum_new     = tok_sum + TOT_W'(value);
  assign reached     = {sum_new, {RAND_BITS{1'b0}}} >= target;
  assign flags.hit   = tok_act && live && reached;
  assign flags.miss  = tok_act && !live;
  assign tok_out_act = tok_act && live && !reached;
  assign tok_out_sum = sum_new;

endmodule

### rtl/frs_checker.sv
`timescale 1ns / 1ps

module frs_checker
  import frs_pkg::*;
#(
  parameter int POP_SIZE     = POP_SIZE_DEF,
  parameter int FITNESS_BITS = FITNESS_BITS_DEF,
  parameter int IDX_W        = $clog2(POP_SIZE),
  parameter int CNT_W        = $clog2(POP_SIZE + 1),
  parameter int TOT_W        = FITNESS_BITS + IDX_W
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              status,
  input logic [IDX_W-1:0]        chosen_index,
  input logic [CNT_W-1:0]        member_count,
  input logic [TOT_W-1:0]        total_fitness,
  input logic [FITNESS_BITS-1:0] best_fitness,
  input logic [FITNESS_BITS-1:0] worst_fitness
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(chosen_index))
    else $error("output request changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> member_count == CNT_W'(POP_SIZE))
    else $error("full status with free room");

  a_none_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NONE |-> chosen_index == '0 && member_count == '0)
    else $error("no-choice status with members or nonzero index");

  a_empty_stats: assert property (@(posedge clk) disable iff (rst)
    out_valid && member_count == '0 |->
      total_fitness == '0 && best_fitness == '0 && worst_fitness == '1)
    else $error("statistics of an empty population are not at their cleared values");

endmodule

bind fitness_roulette_selector_core frs_checker #(
  .POP_SIZE    (POP_SIZE),
  .FITNESS_BITS(FITNESS_BITS)
) u_frs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .chosen_index (chosen_index),
  .member_count (member_count),
  .total_fitness(total_fitness),
  .best_fitness (best_fitness),
  .worst_fitness(worst_fitness)
);
